// ===== hdl/cbfm_pkg.sv =====
// Package for the clock buffer frame manager: widths, action and status codes,
// sequencer states and the frame record type. No dependencies.
package cbfm_pkg;

   localparam int unsigned FRAMES_DEFAULT = 16;
   localparam int unsigned ACTION_W = 3;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned FILE_W = 8;
   localparam int unsigned PAGE_W = 32;
   localparam int unsigned PIN_W = 16;
   localparam logic [PIN_W-1:0] PIN_MAX = {PIN_W{1'b1}};

   localparam logic [ACTION_W-1:0] ACT_READ = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_UNPIN = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_ALLOC = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_DISPOSE = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_FLUSH = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_PINNED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_PINNED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_RESIDENT = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SWEEP,
      S_FLUSH,
      S_OUT
   } state_type;

   typedef struct packed {
      logic                valid;
      logic [PIN_W-1:0]    pin;
      logic                refd;
      logic                dirty;
      logic [FILE_W-1:0]   file;
      logic [PAGE_W-1:0]   page;
   } frame_type;

endpackage

// ===== hdl/cbfm_frame_unit.sv =====
// Shared per-frame evaluation unit: tag compare and pin test on one frame.
// Depends on cbfm_pkg.
module cbfm_frame_unit (
   input  cbfm_pkg::frame_type             frame,
   input  logic [cbfm_pkg::FILE_W-1:0]     file_id,
   input  logic [cbfm_pkg::PAGE_W-1:0]     page_id,
   output logic                            file_match,
   output logic                            tag_match,
   output logic                            pinned
);
   assign file_match = frame.valid && (frame.file == file_id);
   assign tag_match = file_match && (frame.page == page_id);
   assign pinned = (frame.pin != '0);
endmodule

// ===== hdl/clock_buffer_frame_manager.sv =====
// Top level of the clock buffer frame manager: frame table, sequencer and
// result register. Depends on cbfm_pkg and cbfm_frame_unit.
//
// The block handles one request at a time and keeps req_stall high from the
// cycle after acceptance until it is idle again after its last result has
// been taken. A shared unit looks at one frame per cycle. A read, unpin,
// allocate, dispose or unknown request first scans all FRAMES frames for a
// tag match and for any unpinned frame, and its single result is formed in
// the cycle after the scan. A read or allocate miss with some unpinned frame
// also runs the clock sweep between scan and result, one frame per cycle.
// A flush skips the scan and visits frames in order up to the first pinned
// frame of its file, one result per visited frame and one result a cycle
// while results are taken.
module clock_buffer_frame_manager #(
   parameter int unsigned FRAMES = cbfm_pkg::FRAMES_DEFAULT,
   localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [cbfm_pkg::ACTION_W-1:0]  req_action,
   input  logic [cbfm_pkg::FILE_W-1:0]    req_file_id,
   input  logic [cbfm_pkg::PAGE_W-1:0]    req_page_id,
   input  logic                           req_mark_modified,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [cbfm_pkg::STATUS_W-1:0]  rsp_status,
   output logic [IDX_W-1:0]               rsp_frame_index,
   output logic                           rsp_was_resident,
   output logic                           rsp_need_fetch,
   output logic                           rsp_need_writeback,
   output logic [cbfm_pkg::FILE_W-1:0]    rsp_writeback_file,
   output logic [cbfm_pkg::PAGE_W-1:0]    rsp_writeback_page,
   output logic                           rsp_last
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAMES - 1);

   // Frame table; reset clears it, so valid bits and tags are real flops.
   cbfm_pkg::frame_type frames_ff [FRAMES];
   cbfm_pkg::frame_type frames_in [FRAMES];

   cbfm_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0] hand_ff, hand_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic hit_ff, hit_in;
   logic any_free_ff, any_free_in;

   logic [cbfm_pkg::ACTION_W-1:0] act_ff, act_in;
   logic [cbfm_pkg::FILE_W-1:0] file_ff, file_in;
   logic [cbfm_pkg::PAGE_W-1:0] page_ff, page_in;
   logic mod_ff, mod_in;

   // Result register.
   logic                          ovalid_ff, ovalid_in;
   logic [cbfm_pkg::STATUS_W-1:0] ostatus_ff, ostatus_in;
   logic [IDX_W-1:0]              oidx_ff, oidx_in;
   logic ores_ff, ores_in, ofetch_ff, ofetch_in, owb_ff, owb_in, olast_ff, olast_in;
   logic [cbfm_pkg::FILE_W-1:0]   owbf_ff, owbf_in;
   logic [cbfm_pkg::PAGE_W-1:0]   owbp_ff, owbp_in;

   // The shared unit looks at the frame the sequencer points at.
   logic [IDX_W-1:0] probe_idx;
   cbfm_pkg::frame_type probe;
   logic u_file_match, u_tag_match, u_pinned;
   logic req_take, rsp_take;
   logic [IDX_W-1:0] hand_next;

   assign probe_idx = (state_ff == cbfm_pkg::S_SWEEP) ? hand_next : idx_ff;
   assign probe = frames_ff[probe_idx];
   assign hand_next = (hand_ff == LAST_IDX) ? '0 : hand_ff + 1'b1;

   cbfm_frame_unit u_unit (
      .frame       (probe),
      .file_id     (file_ff),
      .page_id     (page_ff),
      .file_match  (u_file_match),
      .tag_match   (u_tag_match),
      .pinned      (u_pinned)
   );

   assign req_take = req_valid && !req_stall;
   assign rsp_take = ovalid_ff && !rsp_stall;
   assign req_stall = (state_ff != cbfm_pkg::S_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cbfm_pkg::S_IDLE: begin
            if (req_take) begin
               state_in = cbfm_pkg::S_SCAN;
            end
         end
         cbfm_pkg::S_SCAN: begin
            if (act_ff == cbfm_pkg::ACT_FLUSH) begin
               state_in = cbfm_pkg::S_FLUSH;
            end else if (idx_ff == LAST_IDX) begin
               if ((act_ff == cbfm_pkg::ACT_READ || act_ff == cbfm_pkg::ACT_ALLOC) &&
                   !hit_in && any_free_in) begin
                  state_in = cbfm_pkg::S_SWEEP;
               end else begin
                  state_in = cbfm_pkg::S_OUT;
               end
            end
         end
         cbfm_pkg::S_SWEEP: begin
            if (!probe.valid || (!probe.refd && !u_pinned)) begin
               state_in = cbfm_pkg::S_OUT;
            end
         end
         cbfm_pkg::S_FLUSH: begin
            if (!ovalid_ff || rsp_take) begin
               if ((u_file_match && u_pinned) || idx_ff == LAST_IDX) begin
                  state_in = cbfm_pkg::S_OUT;
               end
            end
         end
         cbfm_pkg::S_OUT: begin
            if (!ovalid_ff || rsp_take) begin
               if (!ovalid_ff && olast_ff) begin
                  state_in = cbfm_pkg::S_IDLE;
               end
            end
         end
         default: state_in = cbfm_pkg::S_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      for (int i = 0; i < FRAMES; i++) begin
         frames_in[i] = frames_ff[i];
      end
      hand_in = hand_ff;
      idx_in = idx_ff;
      hit_idx_in = hit_idx_ff;
      hit_in = hit_ff;
      any_free_in = any_free_ff;
      act_in = act_ff;
      file_in = file_ff;
      page_in = page_ff;
      mod_in = mod_ff;
      ovalid_in = ovalid_ff && !rsp_take;
      ostatus_in = ostatus_ff;
      oidx_in = oidx_ff;
      ores_in = ores_ff;
      ofetch_in = ofetch_ff;
      owb_in = owb_ff;
      owbf_in = owbf_ff;
      owbp_in = owbp_ff;
      olast_in = olast_ff;
      unique case (state_ff)
         cbfm_pkg::S_IDLE: begin
            if (req_take) begin
               act_in = req_action;
               file_in = req_file_id;
               page_in = req_page_id;
               mod_in = req_mark_modified;
               idx_in = '0;
               hit_in = 1'b0;
               hit_idx_in = '0;
               any_free_in = 1'b0;
               olast_in = 1'b0;
            end
         end
         cbfm_pkg::S_SCAN: begin
            if (act_ff == cbfm_pkg::ACT_FLUSH) begin
               idx_in = '0;
            end else begin
               if (u_tag_match && !hit_ff) begin
                  hit_in = 1'b1;
                  hit_idx_in = idx_ff;
               end
               if (!u_pinned) begin
                  any_free_in = 1'b1;
               end
               if (idx_ff != LAST_IDX) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         cbfm_pkg::S_SWEEP: begin
            hand_in = hand_next;
            if (probe.valid && probe.refd) begin
               frames_in[hand_next].refd = 1'b0;
            end
            if (!probe.valid || (!probe.refd && !u_pinned)) begin
               owb_in = probe.valid && probe.dirty;
               owbf_in = (probe.valid && probe.dirty) ? probe.file : '0;
               owbp_in = (probe.valid && probe.dirty) ? probe.page : '0;
               hit_idx_in = hand_next;
            end
         end
         cbfm_pkg::S_FLUSH: begin
            if (!ovalid_ff || rsp_take) begin
               ovalid_in = 1'b1;
               oidx_in = idx_ff;
               ostatus_in = cbfm_pkg::ST_OK;
               ores_in = u_file_match;
               ofetch_in = 1'b0;
               owb_in = 1'b0;
               owbf_in = '0;
               owbp_in = '0;
               olast_in = (idx_ff == LAST_IDX);
               if (u_file_match && u_pinned) begin
                  ostatus_in = cbfm_pkg::ST_PINNED;
                  olast_in = 1'b1;
               end else if (u_file_match) begin
                  owb_in = probe.dirty;
                  owbf_in = probe.dirty ? probe.file : '0;
                  owbp_in = probe.dirty ? probe.page : '0;
                  frames_in[idx_ff] = '0;
               end
               if (idx_ff != LAST_IDX) begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         cbfm_pkg::S_OUT: begin
            // A single-result request is formed here once the register is free.
            if (!ovalid_ff && !olast_ff) begin
               ovalid_in = 1'b1;
               olast_in = 1'b1;
               ostatus_in = cbfm_pkg::ST_OK;
               oidx_in = '0;
               ores_in = 1'b0;
               ofetch_in = 1'b0;
               case (act_ff) inside
                  cbfm_pkg::ACT_READ, cbfm_pkg::ACT_ALLOC: begin
                     owb_in = owb_ff;
                     if (hit_ff) begin
                        owb_in = 1'b0;
                        owbf_in = '0;
                        owbp_in = '0;
                        oidx_in = hit_idx_ff;
                        ores_in = 1'b1;
                        frames_in[hit_idx_ff].refd = 1'b1;
                        if (frames_ff[hit_idx_ff].pin != cbfm_pkg::PIN_MAX) begin
                           frames_in[hit_idx_ff].pin = frames_ff[hit_idx_ff].pin + 1'b1;
                        end
                     end else if (!any_free_ff) begin
                        ostatus_in = cbfm_pkg::ST_FULL;
                        owb_in = 1'b0;
                        owbf_in = '0;
                        owbp_in = '0;
                     end else begin
                        oidx_in = hit_idx_ff;
                        ofetch_in = (act_ff == cbfm_pkg::ACT_READ);
                        frames_in[hit_idx_ff].valid = 1'b1;
                        frames_in[hit_idx_ff].pin = cbfm_pkg::PIN_W'(1);
                        frames_in[hit_idx_ff].refd = 1'b1;
                        frames_in[hit_idx_ff].dirty = 1'b0;
                        frames_in[hit_idx_ff].file = file_ff;
                        frames_in[hit_idx_ff].page = page_ff;
                     end
                  end
                  cbfm_pkg::ACT_UNPIN: begin
                     owb_in = 1'b0;
                     owbf_in = '0;
                     owbp_in = '0;
                     if (!hit_ff) begin
                        ostatus_in = cbfm_pkg::ST_NOT_RESIDENT;
                     end else begin
                        oidx_in = hit_idx_ff;
                        ores_in = 1'b1;
                        if (frames_ff[hit_idx_ff].pin == '0) begin
                           ostatus_in = cbfm_pkg::ST_NOT_PINNED;
                        end else begin
                           frames_in[hit_idx_ff].pin = frames_ff[hit_idx_ff].pin - 1'b1;
                           if (mod_ff) begin
                              frames_in[hit_idx_ff].dirty = 1'b1;
                           end
                        end
                     end
                  end
                  cbfm_pkg::ACT_DISPOSE: begin
                     owb_in = 1'b0;
                     owbf_in = '0;
                     owbp_in = '0;
                     if (!hit_ff) begin
                        ostatus_in = cbfm_pkg::ST_NOT_RESIDENT;
                     end else begin
                        oidx_in = hit_idx_ff;
                        ores_in = 1'b1;
                        if (frames_ff[hit_idx_ff].pin != '0) begin
                           ostatus_in = cbfm_pkg::ST_PINNED;
                        end else begin
                           frames_in[hit_idx_ff] = '0;
                        end
                     end
                  end
                  default: begin
                     owb_in = 1'b0;
                     owbf_in = '0;
                     owbp_in = '0;
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbfm_pkg::S_IDLE;
         hand_ff <= LAST_IDX;
         ovalid_ff <= 1'b0;
         olast_ff <= 1'b0;
         for (int i = 0; i < FRAMES; i++) begin
            frames_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         hand_ff <= hand_in;
         ovalid_ff <= ovalid_in;
         olast_ff <= olast_in;
         for (int i = 0; i < FRAMES; i++) begin
            frames_ff[i] <= frames_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      hit_idx_ff <= hit_idx_in;
      hit_ff <= hit_in;
      any_free_ff <= any_free_in;
      act_ff <= act_in;
      file_ff <= file_in;
      page_ff <= page_in;
      mod_ff <= mod_in;
      ostatus_ff <= ostatus_in;
      oidx_ff <= oidx_in;
      ores_ff <= ores_in;
      ofetch_ff <= ofetch_in;
      owb_ff <= owb_in;
      owbf_ff <= owbf_in;
      owbp_ff <= owbp_in;
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_status = ostatus_ff;
   assign rsp_frame_index = oidx_ff;
   assign rsp_was_resident = ores_ff;
   assign rsp_need_fetch = ofetch_ff;
   assign rsp_need_writeback = owb_ff;
   assign rsp_writeback_file = owbf_ff;
   assign rsp_writeback_page = owbp_ff;
   assign rsp_last = olast_ff;

`ifndef SYNTHESIS
   a_busy_no_take: assert property (@(posedge clock) disable iff (reset)
      (state_ff != cbfm_pkg::S_IDLE) |-> req_stall)
      else $error("request taken while busy");
   a_idle_no_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cbfm_pkg::S_IDLE) |-> !rsp_valid)
      else $error("result pending while idle");
   a_fetch_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_need_fetch) |-> (rsp_status == cbfm_pkg::ST_OK && !rsp_was_resident))
      else $error("fetch with bad status");
   a_wb_tags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_need_writeback) |-> (rsp_writeback_page == '0))
      else $error("write-back tags without write back");
`endif

endmodule

// ===== tb/sv/clock_buffer_frame_manager_test.sv =====
// Self-checking testbench for the clock buffer frame manager.
// Depends on cbfm_pkg and clock_buffer_frame_manager.
module clock_buffer_frame_manager_test;
   import cbfm_pkg::*;

   localparam int unsigned NF = 16;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [FILE_W-1:0]   file_id;
      logic [PAGE_W-1:0]   page;
      logic                modify;
   } request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [3:0]          frame;
      logic                resident;
      logic                fetch;
      logic                writeback;
      logic [FILE_W-1:0]   wb_file;
      logic [PAGE_W-1:0]   wb_page;
      logic                last;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [ACTION_W-1:0] req_action = '0;
   logic [FILE_W-1:0] req_file_id = '0;
   logic [PAGE_W-1:0] req_page_id = '0;
   logic req_mark_modified = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [3:0] rsp_frame_index;
   logic rsp_was_resident;
   logic rsp_need_fetch;
   logic rsp_need_writeback;
   logic [FILE_W-1:0] rsp_writeback_file;
   logic [PAGE_W-1:0] rsp_writeback_page;
   logic rsp_last;

   clock_buffer_frame_manager #(.FRAMES(NF)) u_dut (.*);

   always #2 clock = ~clock;

   // Predicted frame table, a private copy kept in step with the block.
   frame_type   shadow_frames [NF];
   logic [3:0]  shadow_hand;
   request_type pending_requests [$];
   outcome_type expected_outcomes [$];
   int          mismatch_count = 0;
   int          outcome_count = 0;
   int          request_count = 0;
   bit          quiet = 1'b0;   // high during the stretch with no idling

   function automatic outcome_type make_outcome(logic [STATUS_W-1:0] st, int fr,
         logic res, logic fe, logic wb, logic [FILE_W-1:0] wf,
         logic [PAGE_W-1:0] wp, logic lst);
      outcome_type o;
      o.status = st; o.frame = fr[3:0]; o.resident = res; o.fetch = fe;
      o.writeback = wb; o.wb_file = wf; o.wb_page = wp; o.last = lst;
      return o;
   endfunction

   // Works out the results of one accepted request and updates the table.
   task automatic predict_frame_manager(request_type r);
      int hit;
      int i;
      int steps;
      bit any_free;
      outcome_type o;
      hit = -1;
      for (i = NF - 1; i >= 0; i--)
         if (shadow_frames[i].valid && shadow_frames[i].file == r.file_id &&
               shadow_frames[i].page == r.page)
            hit = i;
      case (r.action) inside
         ACT_READ, ACT_ALLOC: begin
            if (hit >= 0) begin
               shadow_frames[hit].refd = 1'b1;
               if (shadow_frames[hit].pin != PIN_MAX)
                  shadow_frames[hit].pin++;
               expected_outcomes.push_back(make_outcome(ST_OK, hit, 1, 0, 0, 0, 0, 1));
            end else begin
               any_free = 1'b0;
               foreach (shadow_frames[j])
                  if (shadow_frames[j].pin == 0) any_free = 1'b1;
               if (!any_free) begin
                  expected_outcomes.push_back(make_outcome(ST_FULL, 0, 0, 0, 0, 0, 0, 1));
               end else begin
                  o = make_outcome(ST_OK, 0, 0, r.action == ACT_READ, 0, 0, 0, 1);
                  for (steps = 0; steps < 2 * NF + 2; steps++) begin
                     shadow_hand = shadow_hand + 4'd1;
                     i = shadow_hand;
                     if (!shadow_frames[i].valid) break;
                     if (shadow_frames[i].refd) begin
                        shadow_frames[i].refd = 1'b0;
                     end else if (shadow_frames[i].pin == 0) begin
                        if (shadow_frames[i].dirty) begin
                           o.writeback = 1'b1;
                           o.wb_file = shadow_frames[i].file;
                           o.wb_page = shadow_frames[i].page;
                        end
                        break;
                     end
                  end
                  i = shadow_hand;
                  o.frame = shadow_hand;
                  shadow_frames[i] = '{valid: 1'b1, pin: 16'd1, refd: 1'b1, dirty: 1'b0,
                                       file: r.file_id, page: r.page};
                  expected_outcomes.push_back(o);
               end
            end
         end
         ACT_UNPIN: begin
            if (hit < 0)
               expected_outcomes.push_back(make_outcome(ST_NOT_RESIDENT, 0, 0, 0, 0, 0, 0, 1));
            else if (shadow_frames[hit].pin == 0)
               expected_outcomes.push_back(make_outcome(ST_NOT_PINNED, hit, 1, 0, 0, 0, 0, 1));
            else begin
               shadow_frames[hit].pin--;
               if (r.modify) shadow_frames[hit].dirty = 1'b1;
               expected_outcomes.push_back(make_outcome(ST_OK, hit, 1, 0, 0, 0, 0, 1));
            end
         end
         ACT_DISPOSE: begin
            if (hit < 0)
               expected_outcomes.push_back(make_outcome(ST_NOT_RESIDENT, 0, 0, 0, 0, 0, 0, 1));
            else if (shadow_frames[hit].pin != 0)
               expected_outcomes.push_back(make_outcome(ST_PINNED, hit, 1, 0, 0, 0, 0, 1));
            else begin
               shadow_frames[hit] = '0;
               expected_outcomes.push_back(make_outcome(ST_OK, hit, 1, 0, 0, 0, 0, 1));
            end
         end
         ACT_FLUSH: begin
            for (i = 0; i < NF; i++) begin
               if (!shadow_frames[i].valid || shadow_frames[i].file != r.file_id) begin
                  expected_outcomes.push_back(make_outcome(ST_OK, i, 0, 0, 0, 0, 0,
                                                           i == NF - 1));
               end else if (shadow_frames[i].pin != 0) begin
                  expected_outcomes.push_back(make_outcome(ST_PINNED, i, 1, 0, 0, 0, 0, 1));
                  break;
               end else begin
                  expected_outcomes.push_back(make_outcome(ST_OK, i, 1, 0,
                     shadow_frames[i].dirty,
                     shadow_frames[i].dirty ? shadow_frames[i].file : '0,
                     shadow_frames[i].dirty ? shadow_frames[i].page : '0, i == NF - 1));
                  shadow_frames[i] = '0;
               end
            end
         end
         default: expected_outcomes.push_back(make_outcome(ST_OK, 0, 0, 0, 0, 0, 0, 1));
      endcase
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on result %0d: %s got %0h expected %0h",
               outcome_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic queue_request(logic [ACTION_W-1:0] a, logic [FILE_W-1:0] f,
         logic [PAGE_W-1:0] p, logic m);
      pending_requests.push_back('{action: a, file_id: f, page: p, modify: m});
   endtask

   // Driver: presents the oldest pending request, idling now and then.
   // The prediction is made when the block accepts the request.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_frame_manager('{action: req_action, file_id: req_file_id,
                                    page: req_page_id, modify: req_mark_modified});
            request_count++;
            void'(pending_requests.pop_front());
         end
         if ((!req_valid || !req_stall)) begin
            if (pending_requests.size() > 0 &&
                  (quiet || $urandom_range(99) >= 29)) begin
               req_valid <= 1'b1;
               req_action <= pending_requests[0].action;
               req_file_id <= pending_requests[0].file_id;
               req_page_id <= pending_requests[0].page;
               req_mark_modified <= pending_requests[0].modify;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each accepted result against the oldest expectation.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outcomes.size() == 0) begin
               report_mismatch("unexpected result", 0, 0);
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_frame_index !== want.frame)
                  report_mismatch("frame_index", rsp_frame_index, want.frame);
               if (rsp_was_resident !== want.resident)
                  report_mismatch("was_resident", rsp_was_resident, want.resident);
               if (rsp_need_fetch !== want.fetch)
                  report_mismatch("need_fetch", rsp_need_fetch, want.fetch);
               if (rsp_need_writeback !== want.writeback)
                  report_mismatch("need_writeback", rsp_need_writeback, want.writeback);
               if (rsp_writeback_file !== want.wb_file)
                  report_mismatch("writeback_file", rsp_writeback_file, want.wb_file);
               if (rsp_writeback_page !== want.wb_page)
                  report_mismatch("writeback_page", rsp_writeback_page, want.wb_page);
               if (rsp_last !== want.last)
                  report_mismatch("last", rsp_last, want.last);
            end
            outcome_count++;
         end
         rsp_stall <= !quiet && ($urandom_range(99) < 29);
      end
   end

   // Random request, mostly over a small working set so that hits, evictions
   // and write backs are common; now and then any value at all.
   task automatic queue_random_request();
      logic [ACTION_W-1:0] a;
      logic [FILE_W-1:0] f;
      logic [PAGE_W-1:0] p;
      int pick;
      pick = $urandom_range(99);
      if (pick < 35) a = ACT_READ;
      else if (pick < 70) a = ACT_UNPIN;
      else if (pick < 80) a = ACT_ALLOC;
      else if (pick < 90) a = ACT_DISPOSE;
      else if (pick < 96) a = ACT_FLUSH;
      else a = ACTION_W'($urandom_range(7));
      if ($urandom_range(9) == 0) begin
         f = FILE_W'($urandom);
         p = PAGE_W'($urandom);
      end else begin
         f = FILE_W'($urandom_range(2));
         p = PAGE_W'($urandom_range(23));
      end
      queue_request(a, f, p, 1'($urandom_range(1)));
   endtask

   initial begin
      int i;
      // The predicted table starts as the block does after reset.
      foreach (shadow_frames[k]) shadow_frames[k] = '0;
      shadow_hand = 4'(NF - 1);
      // Directed part: field extremes, every action, the special cases.
      queue_request(ACT_UNPIN, 8'd0, 32'd0, 1'b0);          // unpin, not resident
      queue_request(ACT_DISPOSE, 8'd0, 32'd0, 1'b0);        // dispose, not resident
      queue_request(ACT_READ, 8'hFF, 32'hFFFF_FFFF, 1'b0);  // miss into empty frame
      queue_request(ACT_READ, 8'hFF, 32'hFFFF_FFFF, 1'b0);  // hit, pin twice
      queue_request(ACT_DISPOSE, 8'hFF, 32'hFFFF_FFFF, 1'b0); // pinned
      queue_request(ACT_UNPIN, 8'hFF, 32'hFFFF_FFFF, 1'b1);
      queue_request(ACT_UNPIN, 8'hFF, 32'hFFFF_FFFF, 1'b0);
      queue_request(ACT_UNPIN, 8'hFF, 32'hFFFF_FFFF, 1'b0); // not pinned
      queue_request(ACT_ALLOC, 8'h00, 32'h0, 1'b0);          // allocate
      queue_request(ACT_ALLOC, 8'h00, 32'h0, 1'b0);          // allocate of resident
      queue_request(ACT_FLUSH, 8'h00, 32'h0, 1'b0);          // stops at pinned frame
      queue_request(ACT_UNPIN, 8'h00, 32'h0, 1'b1);
      queue_request(ACT_UNPIN, 8'h00, 32'h0, 1'b1);
      queue_request(ACT_FLUSH, 8'hFF, 32'h0, 1'b0);          // dirty write back
      queue_request(ACT_FLUSH, 8'h00, 32'h0, 1'b0);
      queue_request(3'd5, 8'h5A, 32'hA5A5_5A5A, 1'b1);        // unknown actions
      queue_request(3'd7, 8'hA5, 32'h5A5A_A5A5, 1'b0);
      // Fill every frame with pinned pages, then ask for one more.
      for (i = 0; i < NF; i++)
         queue_request(ACT_READ, 8'd7, 32'(i), 1'b0);
      queue_request(ACT_ALLOC, 8'd7, 32'd99, 1'b0);           // all frames pinned
      queue_request(ACT_READ, 8'd7, 32'd98, 1'b0);
      for (i = 0; i < NF; i++)
         queue_request(ACT_UNPIN, 8'd7, 32'(i), i[0]);
      repeat (180) queue_random_request();
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // A stretch with idling, then a stretch with no idling on either side.
      repeat (400) @(posedge clock);
      quiet <= 1'b1;
      repeat (400) @(posedge clock);
      quiet <= 1'b0;
      wait (pending_requests.size() == 0 && !req_valid && expected_outcomes.size() == 0);
      repeat (3 * NF + 10) @(posedge clock);
      $display("Ran %0d requests giving %0d results, every action, full table and flushes.",
               request_count, outcome_count);
      if (mismatch_count == 0 && expected_outcomes.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/cbfm_pkg.sv
hdl/cbfm_frame_unit.sv
hdl/clock_buffer_frame_manager.sv
tb/sv/clock_buffer_frame_manager_test.sv
